>>> rtl/vector_lp_normalizer_assert.svh
// assertion helpers for the lp normalizer
`ifndef VECTOR_LP_NORMALIZER_ASSERT_SVH
`define VECTOR_LP_NORMALIZER_ASSERT_SVH

// same-cycle implication
`define VLN_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vln assertion failed");

// next-cycle implication
`define VLN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vln assertion failed");

`endif

>>> rtl/vln_pkg.sv
package vln_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int ORDER_W    = 2;
    localparam int ACC_W      = 37;
    localparam int RECIP_W    = 32;
    localparam int NORM_W     = 45;
    localparam int OPER_W     = 54;
    localparam int REM_W      = 47;
    localparam int PROD_W     = 48;
    localparam int STEP_W     = 6;
    localparam int SQRT_STEPS = 27;
    localparam int DIV_STEPS  = 32;

    localparam logic [ORDER_W-1:0] ORDER_L1    = 2'd1;
    localparam logic [ORDER_W-1:0] ORDER_RESET = 2'd2;

    typedef enum logic [3:0] {
        S_LOAD,
        S_NORM,
        S_SQRT,
        S_DIV_START,
        S_DIV,
        S_READ,
        S_MUL,
        S_SAT,
        S_EMIT
    } t_state;

    typedef enum logic {
        RD_SQRT,
        RD_DIV
    } t_rd_mode;

    typedef struct packed {
        logic                start;
        t_rd_mode            mode;
        logic [OPER_W-1:0]   operand;
        logic [NORM_W-1:0]   divisor;
    } t_rd_req;

    typedef struct packed {
        logic                done;
        logic [RECIP_W-1:0]  result;
    } t_rd_rsp;

endpackage

>>> rtl/vln_if.sv
interface vln_sample_if;
    import vln_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                       last_sample;
    modport source (output valid, sample_value, last_sample, input ready);
    modport sink (input valid, sample_value, last_sample, output ready);
endinterface

interface vln_result_if;
    import vln_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] scaled_value;
    logic                       last_result;
    modport source (output valid, scaled_value, last_result, input ready);
    modport sink (input valid, scaled_value, last_result, output ready);
endinterface

interface vln_cfg_if;
    import vln_pkg::*;
    logic               valid;
    logic               ready;
    logic [ORDER_W-1:0] norm_order;
    modport source (output valid, norm_order, input ready);
    modport sink (input valid, norm_order, output ready);
endinterface

>>> rtl/vln_root_div.sv
module vln_root_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  vln_pkg::t_rd_req i_req,
    output vln_pkg::t_rd_rsp o_rsp
);
    import vln_pkg::*;

    logic                r_busy;
    t_rd_mode            r_mode;
    logic [STEP_W-1:0]   r_cnt;
    logic [REM_W-1:0]    r_rem;
    logic [OPER_W-1:0]   r_src;
    logic [NORM_W-1:0]   r_div;
    logic [RECIP_W-1:0]  r_q;
    logic                r_done;

    logic [REM_W-1:0]    cand;
    logic [REM_W-1:0]    trial;
    logic                ge;

    // one restoring step: two radicand bits for the root, one dividend bit for the divide
    always_comb begin
        if (r_mode == RD_SQRT) begin
            cand  = {r_rem[REM_W-3:0], r_src[OPER_W-1 -: 2]};
            trial = REM_W'({r_q[SQRT_STEPS-1:0], 2'b01});
        end else begin
            cand  = {r_rem[REM_W-2:0], r_src[OPER_W-1]};
            trial = REM_W'(r_div);
        end
        ge = (cand >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= (i_req.mode == RD_SQRT) ? STEP_W'(SQRT_STEPS - 1)
                                                  : STEP_W'(DIV_STEPS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_mode <= i_req.mode;
            r_q    <= '0;
            r_div  <= i_req.divisor;
            if (i_req.mode == RD_SQRT) begin
                r_rem <= '0;
                r_src <= i_req.operand;
            end else begin
                // quotient fits 32 bits, so the top dividend bits start below the divisor
                r_rem <= REM_W'(i_req.operand[NORM_W:RECIP_W]);
                r_src <= {i_req.operand[RECIP_W-1:0], (OPER_W-RECIP_W)'(0)};
            end
        end else if (r_busy) begin
            r_rem <= ge ? (cand - trial) : cand;
            r_q   <= {r_q[RECIP_W-2:0], ge};
            r_src <= (r_mode == RD_SQRT) ? {r_src[OPER_W-3:0], 2'b00}
                                         : {r_src[OPER_W-2:0], 1'b0};
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_q;

endmodule

>>> rtl/vln_scale.sv
module vln_scale (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [vln_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [vln_pkg::RECIP_W-1:0]         i_recip,
    output logic signed [vln_pkg::SAMPLE_W-1:0] o_scaled
);
    import vln_pkg::*;

    logic [PROD_W-1:0]   r_prod;
    logic                r_neg;
    logic [SAMPLE_W-1:0] mag;
    logic [RECIP_W-1:0]  q;

    assign mag = i_sample[SAMPLE_W-1] ? (~i_sample + 1'b1) : i_sample;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PROD_W'(mag) * PROD_W'(i_recip) + PROD_W'(32768);
            r_neg  <= i_sample[SAMPLE_W-1];
        end
    end

    assign q = r_prod[PROD_W-1:PROD_W-RECIP_W];

    always_comb begin
        if (r_neg) begin
            o_scaled = (q > RECIP_W'(32768)) ? 16'sh8000 : SAMPLE_W'(~q[SAMPLE_W-1:0] + 1'b1);
        end else begin
            o_scaled = (q > RECIP_W'(32767)) ? 16'sh7fff : q[SAMPLE_W-1:0];
        end
    end

endmodule

>>> rtl/vector_lp_normalizer.sv
// load: one cycle per sample, ready held high until the vector ends
// norm: L1 35 cycles, L2 63 cycles (root 28, divide 33) on one shared root/divide unit
// a zero norm skips the divide: L1 2 cycles, L2 30 cycles
// emit: four cycles per result (store read, multiply, saturate, output register)
// vector of n samples with no output stall: n + 35 + 4n cycles (L1), n + 63 + 4n cycles (L2)
// synchronous active-low reset clears control state and sets norm order to L2
module vector_lp_normalizer #(
    parameter int VECTOR_MAX = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    vln_sample_if.sink   i_sample,
    vln_result_if.source o_result,
    vln_cfg_if.sink      i_cfg
);
    import vln_pkg::*;

    `include "vector_lp_normalizer_assert.svh"

    localparam int CW = $clog2(VECTOR_MAX + 1);
    localparam int AW = (VECTOR_MAX > 1) ? $clog2(VECTOR_MAX) : 1;

    t_state              r_state;
    t_state              n_state;
    logic [ORDER_W-1:0]  r_order;
    logic [CW-1:0]       r_count;
    logic [ACC_W-1:0]    r_acc;
    logic                r_l1;
    logic [NORM_W-1:0]   r_norm;
    logic [RECIP_W-1:0]  r_recip;
    logic [AW-1:0]       r_idx;
    logic [SAMPLE_W-1:0] r_rd;
    logic [SAMPLE_W-1:0] r_out_value;
    logic                r_out_last;
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_mem [VECTOR_MAX];

    logic                in_req;
    logic                out_req;
    logic                l1;
    logic [SAMPLE_W-1:0] mag;
    logic [ACC_W-1:0]    term;
    logic                vec_end;
    logic                idx_last;
    t_rd_req             rd_req;
    t_rd_rsp             rd_rsp;
    logic                scale_en;
    logic signed [SAMPLE_W-1:0] scaled;
    logic [NORM_W:0]     numer;

    assign i_cfg.ready = 1'b1;
    assign in_req      = i_sample.valid && i_sample.ready;
    assign out_req     = r_out_valid && o_result.ready;
    assign l1          = (r_order == ORDER_L1);
    assign mag         = i_sample.sample_value[SAMPLE_W-1] ? (~i_sample.sample_value + 1'b1)
                                                           : i_sample.sample_value;
    assign term        = l1 ? ACC_W'(mag) : ACC_W'(mag * mag);
    assign vec_end     = i_sample.last_sample || (r_count + 1'b1 == CW'(VECTOR_MAX));
    assign idx_last    = (r_idx == AW'(r_count - 1'b1));
    // 1.0 in Q1.31 shifted by the 8 fraction bits of the norm, rounded
    assign numer       = (NORM_W+1)'(64'd1 << 39) + (NORM_W+1)'(r_norm >> 1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD:      if (in_req && vec_end) n_state = S_NORM;
            S_NORM:      n_state = r_l1 ? S_DIV_START : S_SQRT;
            S_SQRT:      if (rd_rsp.done) n_state = S_DIV_START;
            S_DIV_START: n_state = (r_norm == '0) ? S_READ : S_DIV;
            S_DIV:       if (rd_rsp.done) n_state = S_READ;
            S_READ:      n_state = S_MUL;
            S_MUL:       n_state = S_SAT;
            S_SAT:       n_state = S_EMIT;
            S_EMIT: begin
                if (out_req) n_state = r_out_last ? S_LOAD : S_READ;
            end
            default:     n_state = S_LOAD;
        endcase
    end

    // control outputs
    always_comb begin
        i_sample.ready = (r_state == S_LOAD);
        scale_en       = (r_state == S_MUL);
        rd_req.start   = 1'b0;
        rd_req.mode    = RD_SQRT;
        rd_req.operand = {1'b0, r_acc, 16'b0};
        rd_req.divisor = r_norm;
        case (r_state)
            S_NORM: begin
                rd_req.start = !r_l1;
            end
            S_DIV_START: begin
                rd_req.start   = (r_norm != '0);
                rd_req.mode    = RD_DIV;
                rd_req.operand = OPER_W'(numer);
            end
            default: begin
                rd_req.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_order     <= ORDER_RESET;
            r_count     <= '0;
            r_acc       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            r_recip     <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) r_order <= i_cfg.norm_order;
            if (in_req) begin
                r_count <= r_count + 1'b1;
                r_acc   <= r_acc + term;
            end
            if (r_state == S_DIV_START && r_norm == '0) r_recip <= '0;
            if (r_state == S_DIV && rd_rsp.done) r_recip <= rd_rsp.result;
            if (r_state == S_SAT) r_out_valid <= 1'b1;
            if (out_req) begin
                r_out_valid <= 1'b0;
                if (r_out_last) begin
                    r_idx   <= '0;
                    r_count <= '0;
                    r_acc   <= '0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_req) begin
            r_mem[r_count[AW-1:0]] <= i_sample.sample_value;
            r_l1 <= l1;
        end
        r_rd <= r_mem[r_idx];
        if (r_state == S_NORM) r_norm <= {r_acc, 8'b0};
        if (r_state == S_SQRT && rd_rsp.done) r_norm <= NORM_W'(rd_rsp.result);
        if (r_state == S_SAT) begin
            r_out_value <= scaled;
            r_out_last  <= idx_last;
        end
    end

    vln_root_div u_root_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rd_req),
        .o_rsp   (rd_rsp)
    );

    vln_scale u_scale (
        .i_clk    (i_clk),
        .i_en     (scale_en),
        .i_sample (r_rd),
        .i_recip  (r_recip),
        .o_scaled (scaled)
    );

    assign o_result.valid        = r_out_valid;
    assign o_result.scaled_value = r_out_value;
    assign o_result.last_result  = r_out_last;

    `VLN_ASSERT_NOW(a_no_load_while_out, i_clk, i_rst_n, r_state == S_LOAD, !r_out_valid)
    `VLN_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, out_req && r_out_last, r_count == '0)
    `VLN_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(VECTOR_MAX))

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import vln_pkg::*;

    localparam int VEC_MAX = 64;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic signed [15:0] scaled_value;
        logic               last_result;
    } t_norm_result;

    class norm_scoreboard;
        logic signed [15:0] samples[$];
        logic [36:0]        norm_acc;
        logic [1:0]         order;
        t_norm_result       pending[$];
        int                 errors;
        int                 vectors;
        int                 results_seen;

        function new();
            norm_acc = '0;
            order = ORDER_RESET;
            errors = 0;
            vectors = 0;
            results_seen = 0;
        endfunction

        function logic [63:0] isqrt(logic [63:0] v);
            logic [63:0] res;
            logic [63:0] b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        function void note_sample(logic signed [15:0] x, logic last);
            logic [63:0] mag;
            logic [63:0] r;
            logic [63:0] recip;
            logic [63:0] q;
            t_norm_result e;
            int n;
            mag = (x < 0) ? 64'(-32'(x)) : 64'(32'(x));
            samples.push_back(x);
            norm_acc = norm_acc + ((order == ORDER_L1) ? mag[36:0] : 37'(mag * mag));
            if (!last && samples.size() < VEC_MAX) return;
            if (order == ORDER_L1) r = 64'(norm_acc) << 8;
            else r = isqrt(64'(norm_acc) << 16);
            recip = (r == 0) ? 0 : (((64'd1 << 39) + (r >> 1)) / r);
            n = samples.size();
            for (int i = 0; i < n; i++) begin
                mag = (samples[i] < 0) ? 64'(-32'(samples[i])) : 64'(32'(samples[i]));
                q = (mag * recip + 64'd32768) >> 16;
                if (samples[i] < 0) e.scaled_value = (q > 32768) ? -16'sd32768 : 16'(-q);
                else e.scaled_value = (q > 32767) ? 16'sd32767 : 16'(q);
                e.last_result = (i == n - 1);
                pending.push_back(e);
            end
            samples.delete();
            norm_acc = '0;
            vectors++;
        endfunction

        function void check_result(logic signed [15:0] v, logic last);
            t_norm_result e;
            results_seen++;
            if (pending.size() == 0) begin
                $error("unexpected result scaled_value=%0d", v);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (v !== e.scaled_value) begin
                $error("scaled_value expected %0d actual %0d", e.scaled_value, v);
                errors++;
            end
            if (last !== e.last_result) begin
                $error("last_result expected %0d actual %0d", e.last_result, last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    vln_sample_if sample_bus();
    vln_result_if result_bus();
    vln_cfg_if    cfg_bus();

    vector_lp_normalizer #(.VECTOR_MAX(VEC_MAX)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_sample(sample_bus.sink), .o_result(result_bus.source), .i_cfg(cfg_bus.sink)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    norm_scoreboard sb = new();
    bit quiet = 0;
    int idle_cycles = 0;
    int samples_sent = 0;

    initial begin
        sample_bus.valid = 0;
        sample_bus.sample_value = 0;
        sample_bus.last_sample = 0;
        cfg_bus.valid = 0;
        cfg_bus.norm_order = 0;
        result_bus.ready = 0;
    end

    // sink side: random stall bursts, none once quiet
    initial begin
        int hold;
        @(posedge i_clk);
        forever begin
            hold = quiet ? 0 : (($urandom_range(0, 2) == 0) ? $urandom_range(1, 16) : 0);
            result_bus.ready <= (hold == 0);
            repeat (hold > 0 ? hold : $urandom_range(1, 20)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && result_bus.valid && result_bus.ready)
            sb.check_result(result_bus.scaled_value, result_bus.last_result);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (sample_bus.valid && sample_bus.ready)
                || (result_bus.valid && result_bus.ready) || (cfg_bus.valid && cfg_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // valid stays high after a request so the next one can follow at once
    task automatic send_sample(logic signed [15:0] x, logic last);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            sample_bus.valid <= 0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        sample_bus.valid <= 1;
        sample_bus.sample_value <= x;
        sample_bus.last_sample <= last;
        do @(posedge i_clk); while (!sample_bus.ready);
        sb.note_sample(x, last);
        samples_sent++;
    endtask

    task automatic drain();
        sample_bus.valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_order(logic [1:0] v);
        drain();
        cfg_bus.valid <= 1;
        cfg_bus.norm_order <= v;
        do @(posedge i_clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 0;
        sb.order = v;
    endtask

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return 16'($urandom_range(0, 7)) - 16'sd3;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_vector(int n);
        for (int i = 0; i < n; i++) send_sample(rand_sample(), i == n - 1);
    endtask

    initial begin
        int len;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // reset order is L2: single sample equal to norm gives saturated one
        send_sample(16'sd1000, 1);
        send_sample(-16'sd32768, 1);
        send_sample(16'sd0, 0); send_sample(16'sd0, 1);
        send_sample(16'sd3, 0); send_sample(-16'sd4, 1);
        write_order(ORDER_L1);
        send_sample(16'sd32767, 1);
        send_sample(-16'sd5, 0); send_sample(16'sd5, 0); send_sample(16'sd0, 1);
        send_sample(16'sd0, 1);
        // order change mid-vector
        send_sample(16'sd100, 0);
        write_order(2'd0);
        send_sample(-16'sd200, 1);
        write_order(2'd3);
        send_sample(16'sd7, 0); send_sample(16'sd7, 1);
        // full store ends the vector without last
        write_order(2'd2);
        for (int i = 0; i < VEC_MAX; i++) send_sample(rand_sample(), 0);
        write_order(ORDER_L1);
        for (int i = 0; i < VEC_MAX; i++) send_sample(-16'sd32768, 0);
        while (samples_sent < 480) begin
            if ($urandom_range(0, 7) == 0) write_order(2'($urandom_range(0, 3)));
            if (samples_sent > 400) quiet = 1;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, VEC_MAX)
                                               : $urandom_range(1, 12);
            send_vector(len);
        end
        drain();
        $display("covered %0d samples in %0d vectors, %0d results checked",
                 samples_sent, sb.vectors, sb.results_seen);
        $display("orders L1 and L2 (plus aliases), zero norms, saturation and full store");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule
